### rtl/rhm_pkg.sv
// Package for the RGB running-median histogram block.
// Holds default sizes, operation codes, transfer structs and the lane control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rhm_pkg;

  localparam int RHM_BIN_COUNT    = 256;
  localparam int RHM_COUNT_WIDTH  = 16;
  // Bins held in one memory row and scanned together in one cycle.
  localparam int RHM_BINS_PER_ROW = 4;
  localparam int RHM_SLOT_W       = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } rhm_op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  red_value;
    logic [7:0]  green_value;
    logic [7:0]  blue_value;
    logic [15:0] window_count;
  } rhm_cmd_t;

  typedef struct packed {
    logic [7:0] median_red;
    logic [7:0] median_green;
    logic [7:0] median_blue;
  } rhm_res_t;

  typedef struct packed {
    logic clr;
    logic upd_rd;
    logic upd_wr;
    logic raise;
    logic scan_rd;
    logic scan_start;
  } rhm_ctrl_t;

endpackage
`default_nettype wire

### rtl/rhm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the per-channel histogram rows.
`timescale 1ns / 1ps
`default_nettype none
module rhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/rhm_lane.sv
// One colour channel: histogram memory, bin update and running-sum median scan.
// Depends on rhm_pkg and rhm_ram.
`timescale 1ns / 1ps
`default_nettype none
module rhm_lane #(
  parameter int BIN_COUNT   = 256,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rhm_pkg::rhm_ctrl_t  ctrl,
  input  wire logic [$clog2((BIN_COUNT + rhm_pkg::RHM_BINS_PER_ROW - 1)
                            / rhm_pkg::RHM_BINS_PER_ROW)-1:0] row,
  input  wire logic [7:0]          bin_value,
  input  wire logic [15:0]         half,
  output logic      [7:0]          median
);
  import rhm_pkg::*;

  localparam int ROW_COUNT = (BIN_COUNT + RHM_BINS_PER_ROW - 1) / RHM_BINS_PER_ROW;
  localparam int ROW_W     = $clog2(ROW_COUNT);
  localparam int IDX_W     = ROW_W + RHM_SLOT_W;
  localparam int ROW_BITS  = RHM_BINS_PER_ROW * COUNT_WIDTH;
  localparam int PRE_W     = COUNT_WIDTH + RHM_SLOT_W;
  localparam int SUM_W     = COUNT_WIDTH + IDX_W;
  localparam int CMP_W     = (SUM_W > 16) ? SUM_W : 16;

  logic [IDX_W-1:0]      value_idx;
  logic [ROW_W-1:0]      value_row;
  logic [RHM_SLOT_W-1:0] value_slot;
  logic                  in_range;

  logic                  we;
  logic [ROW_W-1:0]      waddr;
  logic [ROW_W-1:0]      raddr;
  logic [ROW_BITS-1:0]   wdata;
  logic [ROW_BITS-1:0]   rdata;

  logic [RHM_BINS_PER_ROW-1:0][COUNT_WIDTH-1:0] rd_bins;
  logic [RHM_BINS_PER_ROW-1:0][COUNT_WIDTH-1:0] upd_bins;
  logic [RHM_BINS_PER_ROW-1:0][PRE_W-1:0]       pre;
  logic [RHM_BINS_PER_ROW-1:0][PRE_W-1:0]       pre_q;
  logic [RHM_BINS_PER_ROW-1:0]                  hit;
  logic [RHM_SLOT_W-1:0]                        hit_slot;

  // scan pipeline: read -> prefix -> compare
  logic             scan_q;
  logic [ROW_W-1:0] row_q;
  logic             pre_vld;
  logic [ROW_W-1:0] row_a;
  logic [CMP_W-1:0] sum;
  logic             found;

  assign value_idx  = IDX_W'(bin_value);
  assign value_row  = value_idx[IDX_W-1:RHM_SLOT_W];
  assign value_slot = value_idx[RHM_SLOT_W-1:0];
  assign in_range   = 32'(bin_value) < 32'(BIN_COUNT);

  assign rd_bins = rdata;

  always_comb begin
    for (int j = 0; j < RHM_BINS_PER_ROW; j++) begin
      if (RHM_SLOT_W'(j) == value_slot) begin
        upd_bins[j] = ctrl.raise ? rd_bins[j] + COUNT_WIDTH'(1)
                                 : rd_bins[j] - COUNT_WIDTH'(1);
      end else begin
        upd_bins[j] = rd_bins[j];
      end
    end
  end

  assign raddr = ctrl.upd_rd ? value_row : row;
  assign we    = ctrl.clr | (ctrl.upd_wr & in_range);
  assign waddr = ctrl.clr ? row : value_row;
  assign wdata = ctrl.clr ? '0 : upd_bins;

  rhm_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROW_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // prefix sums within one row
  always_comb begin
    logic [PRE_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < RHM_BINS_PER_ROW; j++) begin
      acc    = acc + PRE_W'(rd_bins[j]);
      pre[j] = acc;
    end
  end

  always_comb begin
    for (int j = 0; j < RHM_BINS_PER_ROW; j++) begin
      hit[j] = (sum + CMP_W'(pre_q[j])) > CMP_W'(half);
    end
    hit_slot = '0;
    for (int j = RHM_BINS_PER_ROW - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_slot = RHM_SLOT_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    row_q <= row;
    row_a <= row_q;
    pre_q <= pre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_q  <= 1'b0;
      pre_vld <= 1'b0;
      sum     <= '0;
      found   <= 1'b0;
      median  <= '0;
    end else begin
      scan_q  <= ctrl.scan_rd;
      pre_vld <= scan_q;
      if (ctrl.scan_start) begin
        sum    <= '0;
        found  <= 1'b0;
        median <= '0;
      end else if (pre_vld) begin
        sum <= sum + CMP_W'(pre_q[RHM_BINS_PER_ROW-1]);
        // keep only the first bin that passes half
        if (!found && (|hit)) begin
          found  <= 1'b1;
          median <= 8'({row_a, hit_slot});
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/rgb_histogram_running_median.sv
// Top level of the RGB running-median histogram: command sequencer, three lanes, merge.
// Depends on rhm_pkg, rhm_lane and rhm_ram.
//
// Usage:
//  - Command channel: a command transfers at a rising edge with start high and busy
//    low. Operations: add pixel, remove pixel, query median, clear all bins.
//  - Result channel: a median query gives one result, held on result for one cycle
//    with result_valid high. Other operations give none. The receiver cannot stall.
//  - Bins sit in memory rows of four; each lane scans one row per cycle.
//  - Add/remove: read-modify-write of one row, busy through the read and write states.
//  - Clear: one row written per cycle, busy until all ROW_COUNT rows are written.
//  - Query: all rows are read in turn, then the last row drains through the lane
//    pipelines before the merge; result_valid rises at the merge and busy drops with it,
//    so the next command may transfer in that same cycle.
//  - Reset: a clearing pass runs through all rows (ROW_COUNT, 64 at 256 bins)
//    with busy high; commands are taken once it ends.
`timescale 1ns / 1ps
`default_nettype none
module rgb_histogram_running_median #(
  parameter int BIN_COUNT   = rhm_pkg::RHM_BIN_COUNT,
  parameter int COUNT_WIDTH = rhm_pkg::RHM_COUNT_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire rhm_pkg::rhm_cmd_t command,
  output rhm_pkg::rhm_res_t      result,
  output logic                   result_valid
);
  import rhm_pkg::*;

  localparam int ROW_COUNT = (BIN_COUNT + RHM_BINS_PER_ROW - 1) / RHM_BINS_PER_ROW;
  localparam int ROW_W     = $clog2(ROW_COUNT);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROW_COUNT - 1);
  localparam logic [1:0]       DRAIN_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] row;
  logic [1:0]       drain;
  rhm_cmd_t         item;
  rhm_ctrl_t        ctrl;
  logic [15:0]      half;
  logic [7:0]       med_red;
  logic [7:0]       med_green;
  logic [7:0]       med_blue;

  assign busy = (state != ST_IDLE);
  assign half = {1'b0, item.window_count[15:1]};

  always_comb begin
    ctrl            = '0;
    ctrl.clr        = (state == ST_CLEAR);
    ctrl.upd_rd     = (state == ST_UPD_RD);
    ctrl.upd_wr     = (state == ST_UPD_WR);
    ctrl.raise      = (rhm_op_t'(item.operation) == OP_ADD);
    ctrl.scan_rd    = (state == ST_SCAN);
    ctrl.scan_start = (state == ST_SCAN) && (row == '0);
  end

  // hold the command for the whole operation
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      row          <= '0;
      drain        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            row <= '0;
            case (rhm_op_t'(command.operation))
              OP_ADD,
              OP_REMOVE: state <= ST_UPD_RD;
              OP_QUERY:  state <= ST_SCAN;
              OP_CLEAR:  state <= ST_CLEAR;
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_UPD_RD: state <= ST_UPD_WR;
        ST_UPD_WR: state <= ST_IDLE;
        ST_CLEAR: begin
          row <= row + ROW_W'(1);
          if (row == ROW_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          row <= row + ROW_W'(1);
          if (row == ROW_LAST) begin
            drain <= '0;
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // wait for the last row to leave the lane pipelines, then merge
          drain <= drain + 2'd1;
          if (drain == DRAIN_LAST) begin
            result.median_red   <= med_red;
            result.median_green <= med_green;
            result.median_blue  <= med_blue;
            result_valid        <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  rhm_lane #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_lane_red (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .row       (row),
    .bin_value (item.red_value),
    .half      (half),
    .median    (med_red)
  );

  rhm_lane #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_lane_green (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .row       (row),
    .bin_value (item.green_value),
    .half      (half),
    .median    (med_green)
  );

  rhm_lane #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_lane_blue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .row       (row),
    .bin_value (item.blue_value),
    .half      (half),
    .median    (med_blue)
  );

endmodule
`default_nettype wire

### rtl/rhm_checker.sv
// Port-level checks for the RGB running-median histogram, bound to the top level.
// Depends on rhm_pkg and rgb_histogram_running_median.
`timescale 1ns / 1ps
`default_nettype none
module rhm_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire rhm_pkg::rhm_cmd_t command,
  input wire logic              result_valid
);
  import rhm_pkg::*;

  // every transfer occupies the block for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after a command transfer");

  // a result only appears once the block has finished
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobed while busy");

  a_result_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // the clearing pass holds off commands straight after reset
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

  // a query keeps the block busy past its first scan row
  a_query_long: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && rhm_op_t'(command.operation) == OP_QUERY) |=> ##1 busy)
    else $error("query finished too early");

endmodule

bind rgb_histogram_running_median rhm_checker u_rhm_checker (.*);
`default_nettype wire

### verif/tb_rgb_histogram_running_median.sv
// Self-checking testbench for rgb_histogram_running_median: directed and sliding-window
// random commands, results checked against a per-channel histogram model kept here.
// Depends on rhm_pkg and the rgb_histogram_running_median RTL.
`timescale 1ns / 1ps
module tb_rgb_histogram_running_median;
  import rhm_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  rhm_cmd_t command = '0;
  logic     busy;
  rhm_res_t result;
  logic     result_valid;

  // Channel 0 red, 1 green, 2 blue.
  logic [RHM_COUNT_WIDTH-1:0] hist_bins [0:2][0:RHM_BIN_COUNT-1];
  rhm_res_t median_expect_q [$];

  int mismatches = 0;
  int n_commands = 0;
  int n_queries = 0;
  int n_clears = 0;
  int n_checked = 0;

  // Sliding-window stimulus state: pixels now in the window and the scene colour.
  logic [23:0] window_px [$];
  logic [7:0]  scene_r, scene_g, scene_b;

  rgb_histogram_running_median uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .result      (result),
    .result_valid(result_valid)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] scan_for_median(input int ch, input logic [15:0] wcount);
    longint unsigned running;
    logic [15:0]     half;
    running = 0;
    half = wcount >> 1;
    for (int i = 0; i < RHM_BIN_COUNT; i++) begin
      running += hist_bins[ch][i];
      if (running > half) return 8'(i);
    end
    return 8'd0;
  endfunction

  function automatic void track_command(input rhm_cmd_t c);
    rhm_res_t want;
    n_commands++;
    case (rhm_op_t'(c.operation))
      OP_ADD: begin
        hist_bins[0][c.red_value]   += 1'b1;
        hist_bins[1][c.green_value] += 1'b1;
        hist_bins[2][c.blue_value]  += 1'b1;
      end
      OP_REMOVE: begin
        hist_bins[0][c.red_value]   -= 1'b1;
        hist_bins[1][c.green_value] -= 1'b1;
        hist_bins[2][c.blue_value]  -= 1'b1;
      end
      OP_CLEAR: begin
        n_clears++;
        for (int ch = 0; ch < 3; ch++)
          for (int i = 0; i < RHM_BIN_COUNT; i++) hist_bins[ch][i] = '0;
      end
      default: begin
        n_queries++;
        want.median_red   = scan_for_median(0, c.window_count);
        want.median_green = scan_for_median(1, c.window_count);
        want.median_blue  = scan_for_median(2, c.window_count);
        median_expect_q.push_back(want);
      end
    endcase
  endfunction

  // Called just after a rising edge; returns just after the edge that took the transfer.
  // Start is left high so a back-to-back command needs no second assignment.
  task automatic send_command(input rhm_op_t op, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [15:0] wcount);
    rhm_cmd_t c;
    c.operation    = op;
    c.red_value    = r;
    c.green_value  = g;
    c.blue_value   = b;
    c.window_count = wcount;
    command <= c;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    track_command(c);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] near(input logic [7:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  always @(posedge clk) begin : check_results
    rhm_res_t want;
    if (!rst && result_valid) begin
      if (median_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d/%0d/%0d with no query outstanding", $realtime,
                   result.median_red, result.median_green, result.median_blue);
      end else begin
        want = median_expect_q.pop_front();
        n_checked++;
        if (result.median_red !== want.median_red ||
            result.median_green !== want.median_green ||
            result.median_blue !== want.median_blue) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: median r/g/b expected %0d/%0d/%0d, got %0d/%0d/%0d", $realtime,
                     want.median_red, want.median_green, want.median_blue,
                     result.median_red, result.median_green, result.median_blue);
        end
      end
    end
  end

  // Always let at least one edge pass, so the next drive lands in a later time step.
  task automatic wait_for_results;
    start <= 1'b0;
    do @(posedge clk); while (median_expect_q.size() != 0);
  endtask

  // Empty histograms: no channel ever passes half, and a zero count passes nothing either.
  task automatic test_empty_window;
    send_command(OP_QUERY, 8'd0, 8'd0, 8'd0, 16'd0);
    send_command(OP_QUERY, 8'hff, 8'hff, 8'hff, 16'hffff);
  endtask

  task automatic test_extreme_values;
    send_command(OP_ADD, 8'd0, 8'd0, 8'd0, 16'd0);
    send_command(OP_ADD, 8'd255, 8'd255, 8'd255, 16'hffff);
    send_command(OP_ADD, 8'd255, 8'd0, 8'd128, 16'd3);
    idle_for(5);
    send_command(OP_QUERY, 8'd0, 8'd0, 8'd0, 16'd3);
    send_command(OP_QUERY, 8'hff, 8'hff, 8'hff, 16'd0);
    send_command(OP_QUERY, 8'd0, 8'd0, 8'd0, 16'hffff);
    send_command(OP_REMOVE, 8'd255, 8'd255, 8'd255, 16'd0);
    send_command(OP_QUERY, 8'd0, 8'd0, 8'd0, 16'd2);
  endtask

  // Lowering an empty bin wraps to the top count; raising it again wraps back to zero.
  task automatic test_bin_wrap;
    send_command(OP_REMOVE, 8'd7, 8'd200, 8'd42, 16'd0);
    send_command(OP_QUERY, 8'd0, 8'd0, 8'd0, 16'hffff);
    send_command(OP_ADD, 8'd7, 8'd200, 8'd42, 16'd0);
    send_command(OP_QUERY, 8'd0, 8'd0, 8'd0, 16'd4);
  endtask

  task automatic test_clear;
    send_command(OP_CLEAR, 8'ha5, 8'h5a, 8'hff, 16'hffff);
    send_command(OP_QUERY, 8'd0, 8'd0, 8'd0, 16'd1);
    send_command(OP_ADD, 8'd128, 8'd64, 8'd32, 16'd0);
    send_command(OP_QUERY, 8'd0, 8'd0, 8'd0, 16'd1);
  endtask

  // Mostly a well-formed sliding window (add newest, drop oldest, query with the true
  // pixel count), with the odd clear, stray remove or arbitrary count mixed in.
  task automatic test_random_window(input int n_items);
    int          mode;
    int          r;
    int          target;
    logic [23:0] px;
    mode = 0;
    target = $urandom_range(1, 48);
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        if ((r < 40 && window_px.size() < target) || window_px.size() == 0) begin
          if ($urandom_range(0, 3) == 0)
            px = 24'($urandom);
          else
            px = {near(scene_r), near(scene_g), near(scene_b)};
          window_px.push_back(px);
          send_command(OP_ADD, px[23:16], px[15:8], px[7:0], 16'($urandom));
        end else begin
          px = window_px.pop_front();
          send_command(OP_REMOVE, px[23:16], px[15:8], px[7:0], 16'($urandom));
        end
      end else if (r < 93) begin
        send_command(OP_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
                     ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                 : 16'(window_px.size()));
      end else if (r < 97) begin
        window_px.delete();
        scene_r = 8'($urandom);
        scene_g = 8'($urandom);
        scene_b = 8'($urandom);
        target = $urandom_range(1, 48);
        send_command(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        send_command(OP_REMOVE, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      end
      idle_for(pick_gap(mode));
    end
  endtask

  task automatic test_hold_until_drained;
    wait_for_results();
    idle_for($urandom_range(1, 20));
  endtask

  initial begin
    scene_r = 8'($urandom);
    scene_g = 8'($urandom);
    scene_b = 8'($urandom);
    for (int ch = 0; ch < 3; ch++)
      for (int i = 0; i < RHM_BIN_COUNT; i++) hist_bins[ch][i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_window();
    test_extreme_values();
    test_bin_wrap();
    test_clear();
    test_hold_until_drained();
    send_command(OP_CLEAR, 8'd0, 8'd0, 8'd0, 16'd0);
    test_random_window(400);
    test_hold_until_drained();
    test_random_window(450);

    wait_for_results();
    repeat (80) @(posedge clk);
    mismatches += median_expect_q.size();
    $display("Ran %0d commands: %0d median queries, %0d clears; %0d results checked",
             n_commands, n_queries, n_clears, n_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rhm_pkg.sv
rtl/rhm_ram.sv
rtl/rhm_lane.sv
rtl/rgb_histogram_running_median.sv
rtl/rhm_checker.sv
verif/tb_rgb_histogram_running_median.sv
